@@ rtl/core/kmh_pkg.sv @@
// shared constants and codes for the k-way merge min-heap
package kmh_pkg;

  localparam int HEAP_DEPTH_DEF  = 16;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int SOURCE_WIDTH    = 4;
  localparam int OCC_WIDTH       = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

@@ rtl/core/kmh_store.sv @@
// heap entry memory: one write port, two registered read ports
module kmh_store #(
  parameter int DEPTH   = 16,
  parameter int ENTRY_W = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [ENTRY_W-1:0]       wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [ENTRY_W-1:0]       rdata_a,
  output logic [ENTRY_W-1:0]       rdata_b
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/core/kway_merge_min_heap.sv @@
// binary min-heap priority queue for a k-way merge of sorted streams
//
// input channel (in_*): one request per transfer, insert (value with its
// source tag) or pop of the minimum. in_stall is high while a request is
// being worked on; the block handles one request at a time.
// result channel (out_*): exactly one result per request, in order, with
// the popped entry (zero on insert or empty), a status code and the
// occupancy after the request.
// steps: an insert's value rises one level per S_UP_CMP step, then S_FINISH; a
// pop reads the root and last entry in S_POP_RD, then sinks the moved entry
// one level per S_DN_CMP step, or finishes when it took the last entry; a pop
// on an empty heap or a refused insert goes straight to S_FINISH. each sift
// level is one read-compare-write of the entry memory, whose read data is registered.
// the result sits in an output register: while out_stall holds it, the next
// request is still taken, and its result waits in the last state until the
// output register frees up.
// reset: rst_n (synchronous, active low) empties the heap and clears
// out_valid; the entry memory itself is not cleared and needs no sweep.
module kway_merge_min_heap #(
  parameter int HEAP_DEPTH  = kmh_pkg::HEAP_DEPTH_DEF,
  parameter int VALUE_WIDTH = kmh_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic signed [VALUE_WIDTH-1:0]     in_value,
  input  logic [kmh_pkg::SOURCE_WIDTH-1:0]  in_source,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [VALUE_WIDTH-1:0]     out_value,
  output logic [kmh_pkg::SOURCE_WIDTH-1:0]  out_source,
  output logic [1:0]                        out_status,
  output logic [kmh_pkg::OCC_WIDTH-1:0]     out_occupancy
);

  import kmh_pkg::*;

  localparam int AW      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW      = $clog2(HEAP_DEPTH + 1);
  localparam int IW      = AW + 2;
  localparam int ENTRY_W = VALUE_WIDTH + SOURCE_WIDTH;

  typedef struct packed {
    logic [SOURCE_WIDTH-1:0]       src;
    logic signed [VALUE_WIDTH-1:0] val;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_UP_CMP,
    S_DN_CMP,
    S_FINISH
  } state_t;

  state_t  state_r, state_nxt;
  logic [AW-1:0] hole_r, hole_nxt;
  logic [CW-1:0] count_r, count_nxt;
  entry_t  x_r, x_nxt;
  entry_t  res_r, res_nxt;
  status_t res_st_r, res_st_nxt;

  logic                          out_valid_r;
  logic signed [VALUE_WIDTH-1:0] out_value_r;
  logic [SOURCE_WIDTH-1:0]       out_source_r;
  status_t                       out_status_r;
  logic [OCC_WIDTH-1:0]          out_occ_r;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [ENTRY_W-1:0] rdata_a, rdata_b;
  entry_t        rd_a, rd_b;

  logic          in_xfer, out_free;
  logic [IW-1:0] lc, rc, ln, rn, cnt_ext;
  logic [AW-1:0] par_cur, par_nxt;
  logic          l_ok, r_ok, pick_rc, move_dn;
  entry_t        cand;

  kmh_store #(
    .DEPTH   (HEAP_DEPTH),
    .ENTRY_W (ENTRY_W)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign rd_a     = entry_t'(rdata_a);
  assign rd_b     = entry_t'(rdata_b);
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // child and parent positions of the current hole
  assign lc      = IW'({hole_r, 1'b1});
  assign rc      = lc + IW'(1);
  assign cnt_ext = IW'(count_r);
  assign par_cur = AW'((hole_r - AW'(1)) >> 1);

  // smaller child, left wins a tie; move only when strictly below the carried entry
  assign l_ok    = lc < cnt_ext;
  assign r_ok    = rc < cnt_ext;
  assign pick_rc = r_ok && (rd_b.val < rd_a.val);
  assign cand    = pick_rc ? rd_b : rd_a;
  assign move_dn = l_ok && (cand.val < x_r.val);

  always_comb begin
    state_nxt  = state_r;
    hole_nxt   = hole_r;
    count_nxt  = count_r;
    x_nxt      = x_r;
    res_nxt    = res_r;
    res_st_nxt = res_st_r;
    we         = 1'b0;
    waddr      = hole_r;
    wdata      = x_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt    = '0;
          res_st_nxt = ST_OK;
          if (in_req_type == REQ_INSERT) begin
            if (count_r == CW'(HEAP_DEPTH)) begin
              res_st_nxt = ST_FULL;
              state_nxt  = S_FINISH;
            end else begin
              x_nxt     = '{src: in_source, val: in_value};
              hole_nxt  = AW'(count_r);
              count_nxt = count_r + CW'(1);
              state_nxt = S_UP_CMP;
            end
          end else begin
            if (count_r == '0) begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_FINISH;
            end else begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_POP_RD;
            end
          end
        end
      end
      S_POP_RD: begin
        res_nxt  = rd_a;
        x_nxt    = rd_b;
        hole_nxt = '0;
        state_nxt = (count_r == '0) ? S_FINISH : S_DN_CMP;
      end
      S_UP_CMP: begin
        we = 1'b1;
        if ((hole_r != '0) && (x_r.val < rd_a.val)) begin
          wdata    = rd_a;
          hole_nxt = par_cur;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (move_dn) begin
          wdata    = cand;
          hole_nxt = pick_rc ? rc[AW-1:0] : lc[AW-1:0];
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // read addresses follow the next hole and next state, not the current ones
  assign par_nxt = AW'((hole_nxt - AW'(1)) >> 1);
  assign ln      = IW'({hole_nxt, 1'b1});
  assign rn      = ln + IW'(1);

  always_comb begin
    case (state_nxt)
      S_POP_RD: begin
        raddr_a = '0;
        raddr_b = AW'(count_r - CW'(1));
      end
      S_DN_CMP: begin
        raddr_a = ln[AW-1:0];
        raddr_b = rn[AW-1:0];
      end
      default: begin
        raddr_a = par_nxt;
        raddr_b = rn[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hole_r   <= hole_nxt;
    x_r      <= x_nxt;
    res_r    <= res_nxt;
    res_st_r <= res_st_nxt;
    if (state_r == S_FINISH && out_free) begin
      out_value_r  <= res_r.val;
      out_source_r <= res_r.src;
      out_status_r <= res_st_r;
      out_occ_r    <= OCC_WIDTH'(count_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_source    = out_source_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

  // writes stay inside the live part of the heap
  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (CW'(waddr) < count_r))
    else $error("heap write outside occupied entries");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HEAP_DEPTH))
    else $error("entry count above heap depth");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_req_type == REQ_POP && count_r != '0)
      |=> (count_r == CW'($past(count_r) - CW'(1))))
    else $error("pop did not remove one entry");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL)
      |-> (out_occupancy == OCC_WIDTH'(HEAP_DEPTH) && out_value == '0))
    else $error("full status with wrong occupancy or value");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY)
      |-> (out_occupancy == '0 && out_value == '0 && out_source == '0))
    else $error("empty status with nonzero fields");

endmodule
